/* rtl/gpms2_pkg.sv */
`default_nettype none
package gpms2_pkg;

	// Row geometry.
	localparam int MAX_COLUMNS = 1024;
	localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
	localparam int CFG_W = 11;
	localparam int CMP_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;

	// Data widths.
	localparam int CELL_W = 16;
	localparam int SUM_W = 32;

	typedef logic signed [CELL_W-1:0] cell_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	// Minus infinity marker and the saturation limits of real sums.
	localparam sum_t NEG_INF = {1'b1, {(SUM_W-1){1'b0}}};
	localparam sum_t SUM_MIN = {1'b1, {(SUM_W-2){1'b0}}, 1'b1};
	localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

	// The three running bests: none, one or two cells zeroed.
	typedef struct packed {
		sum_t two;
		sum_t one;
		sum_t none;
	} bests_t;

	// Adds a cell to a running best; minus infinity absorbs, real sums saturate.
	function automatic sum_t add_cell(input sum_t a, input cell_t v);
		logic signed [SUM_W:0] s;
		sum_t r;
		s = {a[SUM_W-1], a} + {{(SUM_W+1-CELL_W){v[CELL_W-1]}}, v};
		if (a == NEG_INF) begin
			r = NEG_INF;
		end else if (s > $signed({1'b0, SUM_MAX})) begin
			r = SUM_MAX;
		end else if (s < $signed({SUM_MIN[SUM_W-1], SUM_MIN})) begin
			r = SUM_MIN;
		end else begin
			r = s[SUM_W-1:0];
		end
		return r;
	endfunction

	function automatic sum_t max2(input sum_t a, input sum_t b);
		return (a > b) ? a : b;
	endfunction

endpackage
`default_nettype wire

/* rtl/grid_path_max_sum_two_skips.sv */
// Channel  | Direction | Payload (lowest bit first)       | Transfer when
// s_*      | in        | tdata: cell_value; tlast: final  | s_tvalid && s_tready
// m_*      | out       | tdata: best_total                | m_tvalid && m_tready
// cfg_*    | in        | cfg_wr_data: grid_columns        | cfg_wr_en
//
// One cell is taken per cycle. A cell is registered together with the row buffer
// read of its column, and its three bests are formed and written back when that
// stage moves on; the row buffer has one write and one read port.
// Reset clears the control state and the left bests; the row buffer is not cleared.
// The input stalls only when a final cell waits for the output register to drain.
`default_nettype none
module grid_path_max_sum_two_skips (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic signed [gpms2_pkg::CELL_W-1:0] s_tdata,  // [15:0] cell_value
	input  wire logic                              s_tlast,  // final_cell
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic signed [gpms2_pkg::SUM_W-1:0]     m_tdata,  // [31:0] best_total
	input  wire logic                              cfg_wr_en,
	input  wire logic [gpms2_pkg::CFG_W-1:0]       cfg_wr_data  // [10:0] grid_columns
);

	// Configuration and front-end column tracking.
	logic [gpms2_pkg::CFG_W-1:0] cols_q;
	logic [gpms2_pkg::COL_W-1:0] col_q;
	logic                        first_row_q;

	// Stage 1: accepted cell and its row buffer read.
	logic                        valid_s1;
	gpms2_pkg::cell_t            value_s1;
	logic                        last_s1;
	logic                        wrap_s1;
	logic                        first_s1;
	logic                        fwd_s1;
	logic [gpms2_pkg::COL_W-1:0] col_s1;
	gpms2_pkg::bests_t           rd_s1;

	// Left neighbour, last row buffer write, output register.
	gpms2_pkg::bests_t left_q;
	gpms2_pkg::bests_t wr_q;
	logic              out_valid_q;
	gpms2_pkg::sum_t   out_q;

	gpms2_pkg::bests_t row_mem [gpms2_pkg::MAX_COLUMNS];

	logic                        accept;
	logic                        advance;
	logic [gpms2_pkg::CMP_W-1:0] cols_eff;
	logic [gpms2_pkg::CMP_W-1:0] col_next;
	logic                        wrap;
	gpms2_pkg::bests_t           up;
	gpms2_pkg::bests_t           nb;
	gpms2_pkg::sum_t             best;

	// Stage 1 moves on unless a final cell finds the output register still full.
	assign advance = !(valid_s1 && last_s1 && out_valid_q && !m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept = s_tvalid && s_tready;

	// Effective column count: zero acts as one, large values clamp to the buffer depth.
	always_comb begin
		if (cols_q == '0) begin
			cols_eff = gpms2_pkg::CMP_W'(1);
		end else if (gpms2_pkg::CMP_W'(cols_q) > gpms2_pkg::CMP_W'(gpms2_pkg::MAX_COLUMNS)) begin
			cols_eff = gpms2_pkg::CMP_W'(gpms2_pkg::MAX_COLUMNS);
		end else begin
			cols_eff = gpms2_pkg::CMP_W'(cols_q);
		end
		col_next = gpms2_pkg::CMP_W'(col_q) + gpms2_pkg::CMP_W'(1);
		wrap = (col_next >= cols_eff);
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= gpms2_pkg::CFG_W'(1);
		end else if (cfg_wr_en) begin
			cols_q <= cfg_wr_data;
		end
	end

	// Column position advances on every accepted cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			first_row_q <= 1'b1;
		end else if (accept) begin
			if (s_tlast) begin
				col_q <= '0;
				first_row_q <= 1'b1;
			end else if (wrap) begin
				col_q <= '0;
				first_row_q <= 1'b0;
			end else begin
				col_q <= col_next[gpms2_pkg::COL_W-1:0];
			end
		end
	end

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Stage 1 payload. The cell in stage 1 writes its column at this same edge,
	// so a match means the read is stale and the last write is used instead.
	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= s_tdata;
			last_s1 <= s_tlast;
			wrap_s1 <= wrap;
			first_s1 <= first_row_q;
			col_s1 <= col_q;
			fwd_s1 <= valid_s1 && (col_s1 == col_q);
		end
	end

	// Row buffer: registered read for the incoming cell, write from stage 1.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= row_mem[col_q];
		end
		if (valid_s1 && advance) begin
			row_mem[col_s1] <= nb;
		end
	end

	// Upper neighbour and the three new bests.
	always_comb begin
		if (first_s1) begin
			up = '{two: gpms2_pkg::NEG_INF, one: gpms2_pkg::NEG_INF,
				none: gpms2_pkg::NEG_INF};
		end else if (fwd_s1) begin
			up = wr_q;
		end else begin
			up = rd_s1;
		end
		nb.two = gpms2_pkg::max2(
			gpms2_pkg::max2(gpms2_pkg::add_cell(left_q.two, value_s1),
				gpms2_pkg::add_cell(up.two, value_s1)),
			gpms2_pkg::max2(left_q.one, up.one));
		nb.one = gpms2_pkg::max2(
			gpms2_pkg::max2(gpms2_pkg::add_cell(left_q.one, value_s1),
				gpms2_pkg::add_cell(up.one, value_s1)),
			gpms2_pkg::max2(left_q.none, up.none));
		nb.none = gpms2_pkg::add_cell(gpms2_pkg::max2(left_q.none, up.none), value_s1);
		best = gpms2_pkg::max2(gpms2_pkg::max2(nb.none, nb.one), nb.two);
	end

	// Left bests: restart on a final cell, minus infinity at a row wrap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '{two: gpms2_pkg::NEG_INF, one: gpms2_pkg::NEG_INF, none: '0};
		end else if (valid_s1 && advance) begin
			if (last_s1) begin
				left_q <= '{two: gpms2_pkg::NEG_INF, one: gpms2_pkg::NEG_INF, none: '0};
			end else if (wrap_s1) begin
				left_q <= '{two: gpms2_pkg::NEG_INF, one: gpms2_pkg::NEG_INF,
					none: gpms2_pkg::NEG_INF};
			end else begin
				left_q <= nb;
			end
		end
	end

	// Copy of the latest row buffer write for forwarding.
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			wr_q <= nb;
		end
	end

	// Output register holds the grid result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && last_s1 && advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1 && advance) begin
			out_q <= best;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

endmodule
`default_nettype wire
